// ----- hdl/kfs_pkg.sv -----
// Shared types, register indexes, reset values and a helper for the two-state Kalman filter step core.
`timescale 1ns / 1ps
package kfs_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 64;

  localparam logic [CfgIndexW-1:0] REG_TRANSITION  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_CTRL_OBS    = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_PROC_NOISE  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_MEAS_NOISE  = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_INIT_VAR    = 3'd4;

  localparam logic [63:0] TRANSITION_RESET = 64'h0100_0000_0000_0100;
  localparam logic [63:0] CTRL_OBS_RESET   = 64'h0000_0100_0000_0000;
  localparam logic [15:0] MEAS_NOISE_RESET = 16'h0100;
  localparam logic [15:0] INIT_VAR_RESET   = 16'h0100;

  typedef struct packed {
    logic signed [15:0] control_in;
    logic signed [15:0] measurement_in;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] mean_first;
    logic signed [31:0] mean_second;
    logic signed [31:0] var_first;
    logic signed [31:0] cov_upper;
    logic signed [31:0] cov_lower;
    logic signed [31:0] var_second;
    logic signed [31:0] gain_first;
    logic signed [31:0] gain_second;
    logic               degenerate;
  } out_word_t;

  // Sign-extend a Q8.8 lane to a 32-bit multiplier operand.
  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ----- hdl/kalman_filter_step_core.sv -----
// Two-state Kalman filter step built around one shared multiplier and a serial divider.
`timescale 1ns / 1ps
// Flow: an accepted input word runs 44 multiply steps (each a multiply phase and an
//   accumulate phase), a serial division for each of the two gains, and a finish state.
//   A zero innovation variance skips the divider.
// Flow control: a new word is taken only after the last one is finished, since
//   in_ready is high only while the sequencer idles, and a result word still
//   waiting at the output holds the finish state.
// Reset: registers return to their defaults, mean clears, covariance loads the initial
//   variance on the diagonal; no clearing pass is needed.
module kalman_filter_step_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kfs_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kfs_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kfs_pkg::CfgIndexW-1:0]       cfg_index,
  input  logic [kfs_pkg::CfgDataW-1:0]        cfg_data
);
  import kfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    TSH_RAW = 2'd0,
    TSH_L8  = 2'd1,
    TSH_R16 = 2'd2
  } tsh_t;

  localparam logic [5:0] STEP_PRE_DIV = 6'd29;
  localparam logic [5:0] STEP_POST_DIV = 6'd30;
  localparam logic [5:0] STEP_LAST = 6'd43;
  localparam logic [5:0] DIV_LAST = 6'd47;

  state_t state;

  // Configuration registers.
  logic [63:0] trans_reg, ctrl_obs_reg, proc_noise_reg;
  logic [15:0] meas_noise_reg, init_var_reg;

  // Filter state and intermediates in Q16.16, but s is a wider Q26.16 sum; u and z are Q8.8.
  logic signed [31:0] est0, est1, cov0, cov1, cov2, cov3;
  logic signed [31:0] xp0, xp1, t00, t01, t10, t11, pp00, pp01, pp10, pp11;
  logic signed [31:0] h0, h1, k0, k1, y, m00, m01, m10, m11;
  logic signed [41:0] s;
  logic               degen;
  logic signed [15:0] u, z;

  // Sequencer: each step multiplies in phase 0 and accumulates in phase 1.
  logic [5:0]         step;
  logic               ph;
  logic signed [63:0] preg;
  logic signed [65:0] acc;

  // Serial divider.
  logic [47:0] dnum, dq;
  logic [41:0] drem;
  logic [40:0] dden;
  logic [5:0]  dcnt;
  logic        dsel, dneg;

  logic out_valid_r;
  out_word_t out_r;

  // Coefficient lanes.
  logic signed [31:0] a00, a01, a10, a11, b0, b1, c0, c1;
  assign a00 = sx16(trans_reg[15:0]);
  assign a01 = sx16(trans_reg[31:16]);
  assign a10 = sx16(trans_reg[47:32]);
  assign a11 = sx16(trans_reg[63:48]);
  assign b0  = sx16(ctrl_obs_reg[15:0]);
  assign b1  = sx16(ctrl_obs_reg[31:16]);
  assign c0  = sx16(ctrl_obs_reg[47:32]);
  assign c1  = sx16(ctrl_obs_reg[63:48]);

  function automatic logic signed [65:0] rbase(input logic [15:0] r);
    return {{34{r[15]}}, r, 16'b0};
  endfunction

  function automatic logic signed [65:0] wide(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  // Step decode: operands and accumulation control.
  logic signed [31:0] opa, opb;
  logic               first, last, fsh8, neg;
  tsh_t               tsh;
  logic signed [65:0] base, off;

  always_comb begin
    opa = '0;
    opb = '0;
    first = 1'b0;
    last = 1'b0;
    fsh8 = 1'b1;
    neg = 1'b0;
    tsh = TSH_RAW;
    base = '0;
    off = '0;
    unique case (step)
      6'd0: begin opa = a00; opb = est0; first = 1'b1; end
      6'd1: begin opa = a01; opb = est1; end
      6'd2: begin opa = b0; opb = sx16(u); tsh = TSH_L8; last = 1'b1; end
      6'd3: begin opa = a10; opb = est0; first = 1'b1; end
      6'd4: begin opa = a11; opb = est1; end
      6'd5: begin opa = b1; opb = sx16(u); tsh = TSH_L8; last = 1'b1; end
      6'd6: begin opa = a00; opb = cov0; first = 1'b1; end
      6'd7: begin opa = a01; opb = cov2; last = 1'b1; end
      6'd8: begin opa = a00; opb = cov1; first = 1'b1; end
      6'd9: begin opa = a01; opb = cov3; last = 1'b1; end
      6'd10: begin opa = a10; opb = cov0; first = 1'b1; end
      6'd11: begin opa = a11; opb = cov2; last = 1'b1; end
      6'd12: begin opa = a10; opb = cov1; first = 1'b1; end
      6'd13: begin opa = a11; opb = cov3; last = 1'b1; end
      6'd14: begin
        opa = t00; opb = a00; first = 1'b1; base = rbase(proc_noise_reg[15:0]);
      end
      6'd15: begin opa = t01; opb = a01; last = 1'b1; end
      6'd16: begin
        opa = t00; opb = a10; first = 1'b1; base = rbase(proc_noise_reg[31:16]);
      end
      6'd17: begin opa = t01; opb = a11; last = 1'b1; end
      6'd18: begin
        opa = t10; opb = a00; first = 1'b1; base = rbase(proc_noise_reg[47:32]);
      end
      6'd19: begin opa = t11; opb = a01; last = 1'b1; end
      6'd20: begin
        opa = t10; opb = a10; first = 1'b1; base = rbase(proc_noise_reg[63:48]);
      end
      6'd21: begin opa = t11; opb = a11; last = 1'b1; end
      6'd22: begin opa = pp00; opb = c0; first = 1'b1; end
      6'd23: begin opa = pp01; opb = c1; last = 1'b1; end
      6'd24: begin opa = pp10; opb = c0; first = 1'b1; end
      6'd25: begin opa = pp11; opb = c1; last = 1'b1; end
      6'd26: begin
        opa = c0; opb = h0; first = 1'b1; base = {34'b0, meas_noise_reg, 16'b0};
      end
      6'd27: begin opa = c1; opb = h1; last = 1'b1; end
      6'd28: begin opa = c0; opb = xp0; first = 1'b1; end
      6'd29: begin
        opa = c1; opb = xp1; last = 1'b1; neg = 1'b1; off = {{42{z[15]}}, z, 8'b0};
      end
      6'd30: begin
        opa = k0; opb = y; first = 1'b1; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0;
        base = wide(xp0);
      end
      6'd31: begin
        opa = k1; opb = y; first = 1'b1; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0;
        base = wide(xp1);
      end
      6'd32: begin
        opa = k0; opb = c0; first = 1'b1; last = 1'b1; neg = 1'b1; off = 66'sd65536;
      end
      6'd33: begin opa = k0; opb = c1; first = 1'b1; last = 1'b1; neg = 1'b1; end
      6'd34: begin opa = k1; opb = c0; first = 1'b1; last = 1'b1; neg = 1'b1; end
      6'd35: begin
        opa = k1; opb = c1; first = 1'b1; last = 1'b1; neg = 1'b1; off = 66'sd65536;
      end
      6'd36: begin opa = m00; opb = pp00; first = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd37: begin opa = m01; opb = pp10; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd38: begin opa = m00; opb = pp01; first = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd39: begin opa = m01; opb = pp11; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd40: begin opa = m10; opb = pp00; first = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd41: begin opa = m11; opb = pp10; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd42: begin opa = m10; opb = pp01; first = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      6'd43: begin opa = m11; opb = pp11; last = 1'b1; tsh = TSH_R16; fsh8 = 1'b0; end
      default: begin end
    endcase
  end

  // Accumulate path: shift the product, add, shift the sum, optional subtract, saturate.
  logic signed [65:0] praw, term, accn, shv, val;
  logic signed [31:0] sat;

  always_comb begin
    praw = {{2{preg[63]}}, preg};
    unique case (tsh)
      TSH_L8:  term = {praw[57:0], 8'b0};
      TSH_R16: term = praw >>> 16;
      default: term = praw;
    endcase
    accn = (first ? base : acc) + term;
    shv = fsh8 ? (accn >>> 8) : accn;
    val = neg ? (off - shv) : shv;
    if (val > 66'sd2147483647) begin
      sat = 32'sh7fff_ffff;
    end else if (val < -66'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = val[31:0];
    end
  end

  // Divider: one restoring step a cycle on magnitudes.
  logic [41:0] dtry;
  logic        qbit;
  logic [47:0] qfin;
  logic signed [31:0] ksat;
  logic [31:0] hmag1;
  logic [41:0] smag;

  always_comb begin
    dtry = {drem[40:0], dnum[47]};
    qbit = (dtry >= {1'b0, dden});
    qfin = {dq[46:0], qbit};
    if (!dneg) begin
      ksat = (qfin > 48'd2147483647) ? 32'sh7fff_ffff : qfin[31:0];
    end else begin
      ksat = (qfin > 48'd2147483648) ? 32'sh8000_0000 : (32'd0 - qfin[31:0]);
    end
    hmag1 = h1[31] ? (32'd0 - h1) : h1;
    smag = s[41] ? (42'd0 - s) : s;
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      trans_reg <= TRANSITION_RESET;
      ctrl_obs_reg <= CTRL_OBS_RESET;
      proc_noise_reg <= '0;
      meas_noise_reg <= MEAS_NOISE_RESET;
      init_var_reg <= INIT_VAR_RESET;
      est0 <= '0;
      est1 <= '0;
      cov0 <= {8'b0, INIT_VAR_RESET, 8'b0};
      cov1 <= '0;
      cov2 <= '0;
      cov3 <= {8'b0, INIT_VAR_RESET, 8'b0};
      step <= '0;
      ph <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_TRANSITION: trans_reg <= cfg_data;
          REG_CTRL_OBS:   ctrl_obs_reg <= cfg_data;
          REG_PROC_NOISE: proc_noise_reg <= cfg_data;
          REG_MEAS_NOISE: meas_noise_reg <= cfg_data[15:0];
          REG_INIT_VAR:   init_var_reg <= cfg_data[15:0];
          default: begin end
        endcase
      end

      // Drop the taken word unless the finish cycle reloads the output register now.
      if (out_valid_r && out_ready && (state != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            u <= in_data.control_in;
            z <= in_data.measurement_in;
            // Restart: drop the mean and reload the initial covariance first.
            if (in_data.restart) begin
              est0 <= '0;
              est1 <= '0;
              cov0 <= {8'b0, init_var_reg, 8'b0};
              cov1 <= '0;
              cov2 <= '0;
              cov3 <= {8'b0, init_var_reg, 8'b0};
            end
            step <= '0;
            ph <= 1'b0;
            state <= S_CALC;
          end
        end

        S_CALC: begin
          if (!ph) begin
            preg <= opa * opb;
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            acc <= accn;
            if (last) begin
              unique case (step)
                6'd2:  xp0 <= sat;
                6'd5:  xp1 <= sat;
                6'd7:  t00 <= sat;
                6'd9:  t01 <= sat;
                6'd11: t10 <= sat;
                6'd13: t11 <= sat;
                6'd15: pp00 <= sat;
                6'd17: pp01 <= sat;
                6'd19: pp10 <= sat;
                6'd21: pp11 <= sat;
                6'd23: h0 <= sat;
                6'd25: h1 <= sat;
                6'd27: s <= val[41:0];
                6'd29: y <= sat;
                6'd30: est0 <= sat;
                6'd31: est1 <= sat;
                6'd32: m00 <= sat;
                6'd33: m01 <= sat;
                6'd34: m10 <= sat;
                6'd35: m11 <= sat;
                6'd37: cov0 <= sat;
                6'd39: cov1 <= sat;
                6'd41: cov2 <= sat;
                6'd43: cov3 <= sat;
                default: begin end
              endcase
            end
            if (step == STEP_PRE_DIV) begin
              // Set up the first gain division, or skip both gain divisions on a zero variance.
              degen <= (s == '0);
              dsel <= 1'b0;
              dcnt <= '0;
              drem <= '0;
              dq <= '0;
              dden <= smag[40:0];
              dnum <= {(h0[31] ? (32'd0 - h0) : h0), 16'b0};
              dneg <= h0[31] ^ s[41];
              if (s == '0) begin
                k0 <= '0;
                k1 <= '0;
                step <= STEP_POST_DIV;
              end else begin
                state <= S_DIV;
              end
            end else if (step == STEP_LAST) begin
              state <= S_FIN;
            end else begin
              step <= step + 6'd1;
            end
          end
        end

        S_DIV: begin
          if (dcnt == DIV_LAST) begin
            dcnt <= '0;
            drem <= '0;
            dq <= '0;
            if (!dsel) begin
              k0 <= ksat;
              dsel <= 1'b1;
              dnum <= {hmag1, 16'b0};
              dneg <= h1[31] ^ s[41];
            end else begin
              k1 <= ksat;
              step <= STEP_POST_DIV;
              state <= S_CALC;
            end
          end else begin
            drem <= qbit ? (dtry - {1'b0, dden}) : dtry;
            dq <= qfin;
            dnum <= {dnum[46:0], 1'b0};
            dcnt <= dcnt + 6'd1;
          end
        end

        S_FIN: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_r.mean_first <= est0;
            out_r.mean_second <= est1;
            out_r.var_first <= cov0;
            out_r.cov_upper <= cov1;
            out_r.cov_lower <= cov2;
            out_r.var_second <= cov3;
            out_r.gain_first <= k0;
            out_r.gain_second <= k1;
            out_r.degenerate <= degen;
            out_valid_r <= 1'b1;
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
